@@ rtl/assert_macros.svh @@
// Assertion macros used by the allocator top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ffha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int SIZE_W         = 17;
  localparam int HDR_BYTES      = 8;
  localparam int ALIGN_BYTES    = 8;
  localparam int HEAP_BYTES_DEF = 65536;
  localparam logic [SIZE_W-1:0] LIMIT_RESET = 17'd65536;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_IGN  = 2'd2;

  localparam logic REG_HEAP_LIMIT = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [15:0] size;
    logic [15:0] address;
  } request_t;

  typedef struct packed {
    logic [15:0] address_res;
    logic [1:0]  status;
  } result_t;

endpackage

@@ rtl/first_fit_heap_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with address-ordered free list and coalescing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its single result
// appears on result for one cycle with done high, in the first cycle in which
// busy is low again. It must be captured then, since the block cannot be held off.
// A request that is rejected at once (zero size, or a bad free address) is
// busy for one cycle. Any other request walks the free list: each header is
// read from the header memory, which has one read and one write port, and
// evaluated the next cycle, before the next entry is read. A free that
// returns a block at the heap top, unless it is the new list head, walks the
// list a second time to cut the dangling link. No clearing pass follows reset.

module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = HEAP_BYTES / HDR_BYTES;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LNK_W = IDX_W + 1;
  localparam int OFF_W = ((IDX_W + 3 > SIZE_W) ? IDX_W + 3 : SIZE_W) + 1;
  localparam logic [LNK_W-1:0] NIL = LNK_W'(DEPTH);
  localparam logic [OFF_W-1:0] HDR_O = OFF_W'(HDR_BYTES);
  localparam logic [OFF_W-1:0] HEAP_O = OFF_W'(HEAP_BYTES);
  localparam logic [SIZE_W-1:0] ALIGN_M = SIZE_W'(ALIGN_BYTES - 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_ARD  = 5'd2;
  localparam logic [4:0] S_AEV  = 5'd3;
  localparam logic [4:0] S_ASPL = 5'd4;
  localparam logic [4:0] S_AGRW = 5'd5;
  localparam logic [4:0] S_FRDH = 5'd6;
  localparam logic [4:0] S_FRD  = 5'd7;
  localparam logic [4:0] S_FEV  = 5'd8;
  localparam logic [4:0] S_FJ1  = 5'd9;
  localparam logic [4:0] S_FJ2  = 5'd10;
  localparam logic [4:0] S_FT1  = 5'd11;
  localparam logic [4:0] S_FT2  = 5'd12;
  localparam logic [4:0] S_FSHR = 5'd13;
  localparam logic [4:0] S_CRD  = 5'd14;
  localparam logic [4:0] S_CEV  = 5'd15;

  logic [4:0]        state;
  logic              mode_q;
  logic [SIZE_W-1:0] req_q;
  logic [15:0]       addr_q;
  logic [LNK_W-1:0]  ptr, prv, nnx, steps, free_head;
  logic [IDX_W-1:0]  hdr, u_idx;
  logic [SIZE_W-1:0] hsz, psz, nsz;
  logic [SIZE_W-1:0] heap_top, heap_limit;
  logic [15:0]       res_addr;
  logic [1:0]        res_status;

  // header memory
  logic [SIZE_W-1:0] size_mem [DEPTH];
  logic [LNK_W-1:0]  link_mem [DEPTH];
  logic [SIZE_W-1:0] sz_q, sz_wd;
  logic [LNK_W-1:0]  lk_q, lk_wd;
  logic [IDX_W-1:0]  rd_idx, sz_wa, lk_wa;
  logic              sz_we, lk_we;

  // datapath terms
  logic [IDX_W-1:0]  ptr_idx, prv_idx, g_u, a_u, f_hdr;
  logic [LNK_W-1:0]  nx_lk;
  logic [OFF_W-1:0]  ptr_off, prv_end, hdr_off, hdr_end, a_end, g_sum, eff_lim;
  logic [OFF_W-1:0]  total, ht_o, addr_o, f_off;
  logic [SIZE_W-1:0] a_rest, merged, joined, req_rnd;
  logic              a_fit, a_whole, merge, join_n, g_fail, f_bad, s_cond, s_ok;

  assign ptr_idx = ptr[IDX_W-1:0];
  assign prv_idx = prv[IDX_W-1:0];
  assign nx_lk   = lk_q[LNK_W-1] ? NIL : lk_q;
  assign ht_o    = OFF_W'(heap_top);
  assign addr_o  = OFF_W'(addr_q);
  assign ptr_off = OFF_W'({ptr_idx, 3'b000});
  assign hdr_off = OFF_W'({hdr, 3'b000});
  assign prv_end = OFF_W'({prv_idx, 3'b000}) + OFF_W'(psz) + HDR_O;
  assign hdr_end = hdr_off + OFF_W'(hsz) + HDR_O;
  // the cut-off tail starts at the end of the shortened block
  assign a_end   = ptr_off + OFF_W'(a_rest) + HDR_O;
  assign a_u     = a_end[IDX_W+2:3];
  assign g_u     = ht_o[IDX_W+2:3];
  assign total   = OFF_W'(hsz) + HDR_O;

  // allocate: fit, take-whole and split terms
  assign req_rnd = (SIZE_W'(request.size) + ALIGN_M) & ~ALIGN_M;
  assign a_fit   = sz_q >= req_q;
  assign a_whole = OFF_W'(sz_q) < OFF_W'(req_q) + HDR_O + OFF_W'(ALIGN_BYTES);
  assign a_rest  = sz_q - (req_q + SIZE_W'(HDR_BYTES));
  assign eff_lim = (OFF_W'(heap_limit) < HEAP_O) ? OFF_W'(heap_limit) : HEAP_O;
  assign g_sum   = ht_o + HDR_O + OFF_W'(req_q);
  assign g_fail  = g_sum > eff_lim;

  // free: range check, merge and shrink terms
  assign f_bad   = (addr_q < 16'd8) || (addr_o > ht_o) || (addr_q[2:0] != 3'd0);
  assign f_off   = addr_o - HDR_O;
  assign f_hdr   = f_off[IDX_W+2:3];
  assign merge   = prv_end == hdr_off;
  assign merged  = psz + hsz + SIZE_W'(HDR_BYTES);
  assign join_n  = ptr_off == hdr_end;
  assign joined  = hsz + nsz + SIZE_W'(HDR_BYTES);
  assign s_cond  = hdr_end >= ht_o;
  assign s_ok    = (total <= ht_o) && ((ht_o - total) <= OFF_W'(heap_limit));

  assign rd_idx  = (state == S_FRDH) ? hdr : ptr_idx;
  assign busy    = state != S_IDLE;
  assign result  = '{address_res: res_addr, status: res_status};
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_HEAP_LIMIT) ? 32'(heap_limit) : 32'd0;

  // memory write decode per sequencer step
  always_comb begin
    sz_we = 1'b0; sz_wa = ptr_idx; sz_wd = req_q;
    lk_we = 1'b0; lk_wa = prv_idx; lk_wd = NIL;
    unique case (state)
      S_AEV: begin
        if (a_fit && a_whole && prv != NIL) begin
          lk_we = 1'b1; lk_wd = nx_lk;
        end else if (a_fit && !a_whole) begin
          sz_we = 1'b1; sz_wd = a_rest;
        end
      end
      S_ASPL: begin
        sz_we = 1'b1; sz_wa = u_idx;
      end
      S_AGRW: begin
        sz_we = !g_fail; sz_wa = g_u;
        lk_we = !g_fail; lk_wa = g_u;
      end
      S_FJ1, S_FT1: begin
        if (prv != NIL && merge) begin
          sz_we = 1'b1; sz_wa = prv_idx; sz_wd = merged;
        end else if (prv != NIL) begin
          lk_we = 1'b1; lk_wd = LNK_W'(hdr);
        end
      end
      S_FJ2: begin
        lk_we = 1'b1; lk_wa = hdr;
        lk_wd = join_n ? nnx : ptr;
        sz_we = join_n; sz_wa = hdr; sz_wd = joined;
      end
      S_FT2: begin
        lk_we = 1'b1; lk_wa = hdr;
      end
      S_CEV: begin
        lk_we = nx_lk == LNK_W'(hdr); lk_wa = ptr_idx;
      end
      default: begin
      end
    endcase
  end

  // hold header sizes and links
  always_ff @(posedge clk) begin
    if (sz_we) size_mem[sz_wa] <= sz_wd;
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    sz_q <= size_mem[rd_idx];
    lk_q <= link_mem[rd_idx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      free_head  <= NIL;
      heap_top   <= '0;
      heap_limit <= LIMIT_RESET;
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite && pready && paddr[2] == REG_HEAP_LIMIT) begin
        heap_limit <= pwdata[SIZE_W-1:0];
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mode_q <= request.mode;
            req_q  <= req_rnd;
            addr_q <= request.address;
            state  <= S_DISP;
          end
        end
        S_DISP: begin
          ptr   <= free_head;
          prv   <= NIL;
          steps <= '0;
          hdr   <= f_hdr;
          if (mode_q == MODE_ALLOC) begin
            if (req_q == '0) begin
              done <= 1'b1; res_addr <= '0; res_status <= ST_FAIL; state <= S_IDLE;
            end else begin
              state <= S_ARD;
            end
          end else if (f_bad) begin
            done <= 1'b1; res_addr <= '0; res_status <= ST_IGN; state <= S_IDLE;
          end else begin
            state <= S_FRDH;
          end
        end
        S_ARD: begin
          state <= (ptr == NIL || steps == NIL) ? S_AGRW : S_AEV;
        end
        S_AEV: begin
          if (a_fit && a_whole) begin
            if (prv == NIL) free_head <= nx_lk;
            done <= 1'b1; res_status <= ST_OK; state <= S_IDLE;
            res_addr <= 16'(ptr_off + HDR_O);
          end else if (a_fit) begin
            u_idx <= a_u;
            state <= S_ASPL;
          end else begin
            prv   <= ptr;
            ptr   <= nx_lk;
            steps <= steps + 1'b1;
            state <= S_ARD;
          end
        end
        S_ASPL: begin
          done <= 1'b1; res_status <= ST_OK; state <= S_IDLE;
          res_addr <= 16'(OFF_W'({u_idx, 3'b000}) + HDR_O);
        end
        S_AGRW: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (g_fail) begin
            res_addr <= '0; res_status <= ST_FAIL;
          end else begin
            heap_top   <= g_sum[SIZE_W-1:0];
            res_status <= ST_OK;
            res_addr   <= 16'(OFF_W'({g_u, 3'b000}) + HDR_O);
          end
        end
        S_FRDH: begin
          state <= S_FRD;
        end
        S_FRD: begin
          if (steps == '0) hsz <= sz_q;
          state <= (ptr == NIL || steps == NIL) ? S_FT1 : S_FEV;
        end
        S_FEV: begin
          if (ptr > LNK_W'(hdr)) begin
            nsz   <= sz_q;
            nnx   <= nx_lk;
            state <= S_FJ1;
          end else begin
            prv   <= ptr;
            psz   <= sz_q;
            ptr   <= nx_lk;
            steps <= steps + 1'b1;
            state <= S_FRD;
          end
        end
        S_FJ1: begin
          if (prv != NIL && merge) begin
            hdr <= prv_idx;
            hsz <= merged;
          end
          state <= S_FJ2;
        end
        S_FJ2: begin
          if (prv == NIL) free_head <= LNK_W'(hdr);
          done <= 1'b1; res_addr <= '0; res_status <= ST_OK; state <= S_IDLE;
        end
        S_FT1: begin
          if (prv == NIL) begin
            free_head <= LNK_W'(hdr);
            state     <= S_FT2;
          end else if (merge) begin
            hdr   <= prv_idx;
            hsz   <= merged;
            state <= S_FSHR;
          end else begin
            state <= S_FT2;
          end
        end
        S_FT2: begin
          state <= S_FSHR;
        end
        S_FSHR: begin
          res_addr   <= '0;
          res_status <= ST_OK;
          if (s_cond) begin
            if (s_ok) heap_top <= SIZE_W'(ht_o - total);
            if (prv == NIL) begin
              free_head <= NIL;
              done <= 1'b1; state <= S_IDLE;
            end else begin
              if (free_head == LNK_W'(hdr)) free_head <= NIL;
              ptr   <= (free_head == LNK_W'(hdr)) ? NIL : free_head;
              steps <= '0;
              state <= S_CRD;
            end
          end else begin
            done <= 1'b1; state <= S_IDLE;
          end
        end
        S_CRD: begin
          if (ptr == NIL || steps == NIL) begin
            done <= 1'b1; state <= S_IDLE;
          end else begin
            state <= S_CEV;
          end
        end
        S_CEV: begin
          if (nx_lk == LNK_W'(hdr)) begin
            done <= 1'b1; state <= S_IDLE;
          end else begin
            ptr   <= nx_lk;
            steps <= steps + 1'b1;
            state <= S_CRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted request did not start")
  `ASSERT_CLK(a_done_after_busy, done |-> $past(busy), "result without a request")
  `ASSERT_CLK(a_fail_null, (done && result.status != ST_OK) |-> result.address_res == 16'd0, "fail with address")
  `ASSERT_ALWAYS(a_head_range, free_head[LNK_W-1] |-> free_head == NIL, "head out of range")

endmodule
